### rtl/core/lgge_pkg.sv
// shared types and constants for the life grid generation engine
package lgge_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int REG_W       = 7;
  localparam int COORD_W     = 6;
  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [REG_W-1:0] REG_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_GEN   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_CELL,
    S_GLOAD,
    S_GWR,
    S_RESP
  } state_t;

endpackage

### rtl/core/lgge_row_mem.sv
// row-wide grid memory, one write port and one registered read port
module lgge_row_mem
  import lgge_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_HEIGHT,
  parameter int ROW_W = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ROW_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ROW_W-1:0]         rd_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/lgge_row_rule.sv
// b3/s23 update of one whole row from the rows above, at and below it
module lgge_row_rule
  import lgge_pkg::*;
#(
  parameter int ROW_W = DEF_MAX_WIDTH
) (
  input  logic [ROW_W-1:0] above,
  input  logic [ROW_W-1:0] mid,
  input  logic [ROW_W-1:0] below,
  input  logic [ROW_W-1:0] col_mask,
  output logic [ROW_W-1:0] next_row
);

  logic [ROW_W+1:0] above_x;
  logic [ROW_W+1:0] mid_x;
  logic [ROW_W+1:0] below_x;

  assign above_x = {1'b0, above, 1'b0};
  assign mid_x   = {1'b0, mid, 1'b0};
  assign below_x = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    cnt = '0;
    for (int c = 0; c < ROW_W; c++) begin
      cnt = 4'(above_x[c]) + 4'(above_x[c+1]) + 4'(above_x[c+2])
          + 4'(mid_x[c])                      + 4'(mid_x[c+2])
          + 4'(below_x[c]) + 4'(below_x[c+1]) + 4'(below_x[c+2]);
      next_row[c] = col_mask[c] &
                    ((cnt == BIRTH_COUNT) || (mid[c] && (cnt == SURVIVE_COUNT)));
    end
  end

endmodule

### rtl/core/life_grid_generation_engine.sv
// top level: request sequencer around the row memory and row update logic
//
// usage
//   in channel: one request per item, op in in_tuser, cell coordinates and
//   value in in_tdata. every request not cut short by a cfg write returns exactly one
//   result on the out channel (cell_state in out_tdata bit 0, zero except for reads).
//   cfg channel: index 0 grid width, index 1 grid height; a write clears the
//   grid, always taken, and holds off requests while the clear runs.
// steps and throughput (one request at a time)
//   write cell, read cell: row read, modify/write, result
//   generation: one row per cycle through the row memory, limited by its
//   single read port; an empty grid goes straight to the result
//   clear: all rows of the memory, one row cleared per cycle
// reset
//   synchronous, rst_n low; afterwards a clearing pass over every row
//   runs before in_tready rises; size registers return to 64
// stall
//   results wait in a one-entry output register; a new request is taken
//   while it waits, but its own result waits until the register is free
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cell_x[5:0], cell_y[11:6], cell_value[12]
  input  logic [IN_USER_W-1:0]  in_tuser,   // op[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cell_state[0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int HX = HW + 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);

  state_t               state_r, state_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        x_r, x_nxt;
  logic                 v_r, v_nxt;
  op_t                  op_r, op_nxt;
  logic                 inside_r, inside_nxt;
  logic                 res_r, res_nxt;
  logic                 resp_r, resp_nxt;
  logic [MAX_WIDTH-1:0] above_r, above_nxt;
  logic [MAX_WIDTH-1:0] mid_r, mid_nxt;
  logic [REG_W-1:0]     grid_w_r, grid_w_nxt;
  logic [REG_W-1:0]     grid_h_r, grid_h_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_bit_r, out_bit_nxt;
  logic [RW-1:0]        rd_addr_hold_r, rd_addr_hold_nxt;

  logic [COORD_W-1:0]   in_x;
  logic [COORD_W-1:0]   in_y;
  logic                 in_v;
  op_t                  in_op;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 in_inside;
  logic                 grid_empty;
  logic                 out_free;
  logic [WW-1:0]        used_w;
  logic [HW-1:0]        used_h;
  logic [HX-1:0]        row_p1;
  logic [HX-1:0]        row_p2;
  logic                 last_row;
  logic [MAX_WIDTH-1:0] col_mask;
  logic [MAX_WIDTH-1:0] below;
  logic [MAX_WIDTH-1:0] new_row;

  logic                 wr_en;
  logic [RW-1:0]        wr_addr;
  logic [MAX_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [RW-1:0]        rd_addr;
  logic [MAX_WIDTH-1:0] rd_data;

  assign in_x  = in_tdata[COORD_W-1:0];
  assign in_y  = in_tdata[2*COORD_W-1:COORD_W];
  assign in_v  = in_tdata[2*COORD_W];
  assign in_op = op_t'(in_tuser);

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign used_w = (32'(grid_w_r) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(grid_w_r);
  assign used_h = (32'(grid_h_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(grid_h_r);

  assign in_inside  = (32'(in_x) < 32'(used_w)) && (32'(in_y) < 32'(used_h));
  assign grid_empty = (used_w == '0) || (used_h == '0);

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      col_mask[c] = (c < 32'(used_w));
    end
  end

  assign row_p1   = HX'(row_r) + HX'(1);
  assign row_p2   = HX'(row_r) + HX'(2);
  assign last_row = (row_p1 == HX'(used_h));
  assign below    = (row_p1 < HX'(used_h)) ? rd_data : '0;

  lgge_row_mem #(
    .DEPTH (MAX_HEIGHT),
    .ROW_W (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgge_row_rule #(
    .ROW_W (MAX_WIDTH)
  ) u_rule (
    .above    (above_r),
    .mid      (mid_r),
    .below    (below),
    .col_mask (col_mask),
    .next_row (new_row)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_WRITE, OP_READ: state_nxt = S_CELL;
            OP_GEN:            state_nxt = grid_empty ? S_RESP : S_GLOAD;
            OP_CLEAR:          state_nxt = S_CLR;
            default:           state_nxt = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        if (row_r == LAST_ROW) begin
          state_nxt = resp_r ? S_RESP : S_IDLE;
        end
      end
      S_CELL:  state_nxt = S_RESP;
      S_GLOAD: state_nxt = S_GWR;
      S_GWR: begin
        if (last_row) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_acc) begin
      state_nxt = S_CLR;
    end
  end

  // datapath and memory control
  always_comb begin
    row_nxt          = row_r;
    x_nxt            = x_r;
    v_nxt            = v_r;
    op_nxt           = op_r;
    inside_nxt       = inside_r;
    res_nxt          = res_r;
    resp_nxt         = resp_r;
    above_nxt        = above_r;
    mid_nxt          = mid_r;
    grid_w_nxt       = grid_w_r;
    grid_h_nxt       = grid_h_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_bit_nxt      = out_bit_r;
    rd_addr_hold_nxt = rd_addr_hold_r;
    wr_en            = 1'b0;
    wr_addr          = row_r;
    wr_data          = '0;
    rd_en            = 1'b0;
    rd_addr          = RW'(in_y);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt            = CW'(in_x);
          v_nxt            = in_v;
          op_nxt           = in_op;
          inside_nxt       = in_inside;
          res_nxt          = 1'b0;
          row_nxt          = '0;
          above_nxt        = '0;
          rd_addr_hold_nxt = RW'(in_y);
          case (in_op)
            OP_WRITE, OP_READ: begin
              rd_en   = in_inside;
              rd_addr = RW'(in_y);
            end
            OP_GEN: begin
              rd_en   = !grid_empty;
              rd_addr = '0;
            end
            OP_CLEAR: resp_nxt = 1'b1;
            default:  resp_nxt = resp_r;
          endcase
        end
      end
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = row_r;
        wr_data = '0;
        if (row_r == LAST_ROW) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
      S_CELL: begin
        wr_en        = (op_r == OP_WRITE) && inside_r;
        wr_addr      = rd_addr_hold_r;
        wr_data      = rd_data;
        wr_data[x_r] = v_r;
        res_nxt      = (op_r == OP_READ) && inside_r && rd_data[x_r];
      end
      S_GLOAD: begin
        mid_nxt = rd_data;
        rd_en   = (row_p1 < HX'(used_h));
        rd_addr = RW'(row_p1);
      end
      S_GWR: begin
        wr_en     = 1'b1;
        wr_addr   = row_r;
        wr_data   = new_row;
        above_nxt = mid_r;
        mid_nxt   = below;
        rd_en     = !last_row && (row_p2 < HX'(used_h));
        rd_addr   = RW'(row_p2);
        if (!last_row) begin
          row_nxt = row_r + RW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = res_r;
          resp_nxt      = 1'b0;
        end
      end
      default: begin
        row_nxt = '0;
      end
    endcase

    if (cfg_acc) begin
      row_nxt = '0;
      if (cfg_index == CFG_IDX_WIDTH) begin
        grid_w_nxt = cfg_data;
      end else if (cfg_index == CFG_IDX_HEIGHT) begin
        grid_h_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      row_r       <= '0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
      grid_w_r    <= REG_RESET;
      grid_h_r    <= REG_RESET;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
      grid_w_r    <= grid_w_nxt;
      grid_h_r    <= grid_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r            <= x_nxt;
    v_r            <= v_nxt;
    op_r           <= op_nxt;
    inside_r       <= inside_nxt;
    res_r          <= res_nxt;
    above_r        <= above_nxt;
    mid_r          <= mid_nxt;
    out_bit_r      <= out_bit_nxt;
    rd_addr_hold_r <= rd_addr_hold_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_bit_r};

endmodule

### rtl/core/lgge_checker.sv
// port-level assertions for the life grid generation engine, bound to the top level
module lgge_checker
  import lgge_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [REG_W-1:0]      cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // only the cell state bit may be set
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:1] == '0)
    else $error("result padding not zero");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a size write starts a clear that blocks requests
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("request taken during clear");

  // a result never appears in the cycle after a request was taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result before work done");

endmodule

bind life_grid_generation_engine lgge_checker u_lgge_checker (.*);

### tb/tb_top.sv
// testbench top: drives cell, generation and clear requests and checks every result
`timescale 1ns / 1ps

module tb_top;
  import lgge_pkg::*;

  localparam int GRID_CELLS   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int END_WAIT     = 80;

  typedef enum int {
    MODE_NORMAL,
    MODE_NO_IDLE,
    MODE_HOLD_OFF
  } phase_mode_t;

  class life_grid_scoreboard;
    bit               cells [GRID_CELLS];
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    bit               cell_state_q [$];
    int               errors;

    function new();
      width_reg  = REG_RESET;
      height_reg = REG_RESET;
      errors     = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      foreach (cells[i]) cells[i] = 1'b0;
    endfunction

    function int span(logic [REG_W-1:0] r, int max_size);
      return (r > max_size) ? max_size : int'(r);
    endfunction

    function int pending();
      return cell_state_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == CFG_IDX_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
      clear_grid();
    endfunction

    // every cell from a snapshot of the previous generation, outside counts as dead
    function void next_generation();
      bit snap [GRID_CELLS];
      int w, h, x, y, dx, dy, nx, ny, live, i;
      w = span(width_reg, DEF_MAX_WIDTH);
      h = span(height_reg, DEF_MAX_HEIGHT);
      snap = cells;
      for (y = 0; y < h; y++) begin
        for (x = 0; x < w; x++) begin
          live = 0;
          for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
              nx = x + dx;
              ny = y + dy;
              if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h) begin
                live += snap[ny * DEF_MAX_WIDTH + nx];
              end
            end
          end
          i = y * DEF_MAX_WIDTH + x;
          if (!snap[i] && live == BIRTH_COUNT) begin
            cells[i] = 1'b1;
          end else if (snap[i] && live != SURVIVE_COUNT && live != BIRTH_COUNT) begin
            cells[i] = 1'b0;
          end
        end
      end
    endfunction

    function void note_request(op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic v);
      bit in_grid;
      bit state;
      int i;
      in_grid = (x < span(width_reg, DEF_MAX_WIDTH)) && (y < span(height_reg, DEF_MAX_HEIGHT));
      i = int'(y) * DEF_MAX_WIDTH + int'(x);
      state = 1'b0;
      case (op)
        OP_WRITE: begin
          if (in_grid) cells[i] = v;
        end
        OP_READ: begin
          if (in_grid) state = cells[i];
        end
        OP_GEN: begin
          next_generation();
        end
        default: begin
          clear_grid();
        end
      endcase
      cell_state_q.push_back(state);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      bit want;
      if (cell_state_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual cell_state %0b", $time, data[0]);
      end else begin
        want = cell_state_q.pop_front();
        if (data[0] !== want) begin
          errors++;
          $display("%0t: cell_state mismatch, expected %0b actual %0b", $time, want, data[0]);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // cell_x[5:0], cell_y[11:6], cell_value[12]
  logic [IN_USER_W-1:0]  in_tuser = '0;   // op[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // cell_state[0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data = '0;

  life_grid_scoreboard life_sb;
  bit                  no_idle = 1'b0;
  bit                  hold_off_req = 1'b0;

  life_grid_generation_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, v, y, x};
    do @(posedge clk); while (!in_tready);
    life_sb.note_request(op, x, y, v);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (life_sb.pending() != 0);
  endtask

  task automatic write_size(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    life_sb.set_reg(CFG_IDX_WIDTH, w);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    life_sb.set_reg(CFG_IDX_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // seed a small window of the grid, then mix writes, reads, generations and clears with some noise
  task automatic run_phase(logic [REG_W-1:0] w, logic [REG_W-1:0] h, int n,
                           phase_mode_t mode);
    int uw, uh, ww, wh, wx0, wy0, r, k;
    logic [COORD_W-1:0] x, y;
    logic v;
    op_t op;
    write_size(w, h);
    uw  = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w);
    uh  = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(h);
    ww  = (uw < 8) ? uw : 8;
    wh  = (uh < 8) ? uh : 8;
    wx0 = $urandom_range(0, uw - ww);
    wy0 = $urandom_range(0, uh - wh);
    no_idle = (mode != MODE_NORMAL);
    if (mode == MODE_HOLD_OFF) hold_off_req = 1'b1;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 9) < 7);
      if (ww == 0 || wh == 0) begin
        x = COORD_W'($urandom_range(0, 63));
        y = COORD_W'($urandom_range(0, 63));
      end else begin
        x = COORD_W'(wx0 + $urandom_range(0, ww - 1));
        y = COORD_W'(wy0 + $urandom_range(0, wh - 1));
      end
      if (k < 4) begin
        op = OP_WRITE;
        v  = 1'b1;
      end else if (r < 35) begin
        op = OP_WRITE;
      end else if (r < 70) begin
        op = OP_READ;
      end else if (r < 85) begin
        op = OP_GEN;
      end else if (r < 88) begin
        op = OP_CLEAR;
      end else begin
        op = op_t'($urandom_range(0, 3));
        x  = COORD_W'($urandom_range(0, 63));
        y  = COORD_W'($urandom_range(0, 63));
        v  = 1'($urandom_range(0, 1));
      end
      send_request(op, x, y, v);
    end
    in_tvalid <= 1'b0;
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) life_sb.check_result(out_tdata);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD;
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (no_idle || r < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    life_sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corners of the full grid, edge births with no wraparound, a blinker, clear
    send_request(OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_request(OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_request(OP_READ, 6'd0, 6'd0, 1'b0);
    send_request(OP_READ, 6'd63, 6'd63, 1'b1);
    send_request(OP_WRITE, 6'd63, 6'd63, 1'b0);
    send_request(OP_READ, 6'd63, 6'd63, 1'b0);
    send_request(OP_WRITE, 6'd0, 6'd62, 1'b1);
    send_request(OP_WRITE, 6'd0, 6'd63, 1'b1);
    send_request(OP_WRITE, 6'd1, 6'd63, 1'b1);
    send_request(OP_GEN, 6'd63, 6'd0, 1'b1);
    send_request(OP_READ, 6'd1, 6'd62, 1'b0);
    send_request(OP_READ, 6'd63, 6'd62, 1'b0);
    send_request(OP_READ, 6'd0, 6'd0, 1'b0);
    send_request(OP_WRITE, 6'd10, 6'd10, 1'b1);
    send_request(OP_WRITE, 6'd11, 6'd10, 1'b1);
    send_request(OP_WRITE, 6'd12, 6'd10, 1'b1);
    send_request(OP_GEN, 6'd0, 6'd0, 1'b0);
    send_request(OP_READ, 6'd11, 6'd9, 1'b0);
    send_request(OP_READ, 6'd11, 6'd11, 1'b1);
    send_request(OP_READ, 6'd10, 6'd10, 1'b0);
    send_request(OP_CLEAR, 6'd42, 6'd21, 1'b1);
    send_request(OP_READ, 6'd11, 6'd11, 1'b0);
    send_request(OP_READ, 6'd0, 6'd63, 1'b0);
    in_tvalid <= 1'b0;
    wait_drained();

    run_phase(7'd1, 7'd1, 8, MODE_NORMAL);
    run_phase(7'd0, 7'd9, 4, MODE_NORMAL);
    run_phase(7'd9, 7'd0, 4, MODE_NORMAL);
    run_phase(7'd127, 7'd127, 12, MODE_NORMAL);
    run_phase(7'd5, 7'd5, 16, MODE_HOLD_OFF);
    run_phase(7'd3, 7'd64, 12, MODE_NORMAL);
    run_phase(7'd64, 7'd3, 12, MODE_NORMAL);
    run_phase(7'd8, 7'd6, 16, MODE_NO_IDLE);
    run_phase(7'd100, 7'd2, 10, MODE_NORMAL);
    run_phase(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)), 10, MODE_NORMAL);
    run_phase(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)), 10, MODE_NORMAL);

    repeat (END_WAIT) @(posedge clk);
    if (life_sb.errors == 0 && life_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
